>>> hdl/pgpr_pkg.sv
// Shared types and codes for the phase generator with period retiming.
package pgpr_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_PERIOD = 2'd1,
    CMD_START      = 2'd2,
    CMD_STOP       = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [19:0] period_request;
  } in_t;

  typedef struct packed {
    logic [31:0] timer_count;
    logic [15:0] phase_tick;
    logic [15:0] phase_turns;
    logic [15:0] period_now;
    logic        running;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_APPLY,
    ST_REM,
    ST_MUL,
    ST_RELOAD,
    ST_PH_GO,
    ST_PH,
    ST_FRAC_GO,
    ST_FRAC,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    DIV_COUNT,
    DIV_PRODUCT,
    DIV_FRACTION
  } div_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     apply;
    logic     div_start;
    div_sel_e div_sel;
    logic     mul_load;
    logic     commit_reload;
    logic     ph_load;
    logic     turns_load;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic reload_needed;
    logic div_done;
  } dp_stat_t;

endpackage

>>> hdl/pgpr_div.sv
// Restoring divider with a 16-bit divisor, one quotient bit per cycle.
module pgpr_div
  import pgpr_pkg::*;
#(
  parameter int unsigned DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [15:0]   divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [15:0]   rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] q_q, q_d;
  logic [16:0]   r_q, r_d;
  logic [15:0]   d_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [16:0]   r_sh;
  logic          fits;

  assign r_sh = {r_q[15:0], q_q[DW-1]};
  assign fits = (r_sh >= {1'b0, d_q});

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      q_d    = dividend_i;
      r_d    = '0;
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      q_d   = {q_q[DW-2:0], fits};
      r_d   = fits ? (r_sh - {1'b0, d_q}) : r_sh;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    if (start_i) begin
      d_q <= (divisor_i == 16'd0) ? 16'd1 : divisor_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;
  assign rem_o  = r_q[15:0];

endmodule

>>> hdl/pgpr_dpath.sv
// Datapath: counter, period, run flag, reload product, divider and result register.
module pgpr_dpath
  import pgpr_pkg::*;
#(
  parameter int unsigned MIN_PERIOD = 2,
  parameter int unsigned MAX_PERIOD = 65535,
  parameter int unsigned TICK_BITS  = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_t      in_data_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output out_t     out_data_o
);

  localparam int unsigned DW = (TICK_BITS > 32) ? TICK_BITS : 32;

  in_t                  in_q;
  logic [TICK_BITS-1:0] count_q;
  logic [15:0]          period_q;
  logic                 started_q;
  logic [31:0]          prod_q;
  logic [15:0]          ph_q;
  logic [15:0]          turns_q;
  out_t                 out_q;

  logic [15:0]   np;
  logic [DW-1:0] div_dividend;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [15:0]   div_rem;

  // Clamp the requested period.
  always_comb begin
    if (in_q.period_request < 20'(MIN_PERIOD)) begin
      np = 16'(MIN_PERIOD);
    end else if (in_q.period_request > 20'(MAX_PERIOD)) begin
      np = 16'(MAX_PERIOD);
    end else begin
      np = in_q.period_request[15:0];
    end
  end

  always_comb begin
    case (cmd_i.div_sel)
      DIV_COUNT:    div_dividend = DW'(count_q);
      DIV_PRODUCT:  div_dividend = DW'(prod_q);
      DIV_FRACTION: div_dividend = DW'({ph_q, 16'h0000});
      default:      div_dividend = DW'(count_q);
    endcase
  end

  pgpr_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (period_q),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign stat_o.reload_needed = (in_q.command == CMD_SET_PERIOD) && (np != period_q);
  assign stat_o.div_done      = div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      period_q  <= 16'(MAX_PERIOD);
      started_q <= 1'b0;
    end else begin
      if (cmd_i.apply) begin
        case (in_q.command)
          CMD_TICK: begin
            if (started_q) begin
              count_q <= count_q + 1'b1;
            end
          end
          CMD_START: started_q <= 1'b1;
          CMD_STOP:  started_q <= 1'b0;
          default:   ;
        endcase
      end
      if (cmd_i.commit_reload) begin
        count_q  <= div_quot[TICK_BITS-1:0];
        period_q <= np;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_load) begin
      prod_q <= 32'(div_rem) * 32'(np);
    end
    if (cmd_i.ph_load) begin
      ph_q <= div_rem;
    end
    if (cmd_i.turns_load) begin
      turns_q <= div_quot[15:0];
    end
    if (cmd_i.out_load) begin
      out_q.timer_count <= 32'(count_q);
      out_q.phase_tick  <= ph_q;
      out_q.phase_turns <= turns_q;
      out_q.period_now  <= period_q;
      out_q.running     <= started_q;
    end
  end

  assign out_data_o = out_q;

endmodule

>>> hdl/pgpr_ctrl.sv
// Controller: sequences one item through the datapath and owns the handshakes.
module pgpr_ctrl
  import pgpr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_APPLY;
      ST_APPLY:   state_d = stat_i.reload_needed ? ST_REM : ST_PH_GO;
      ST_REM:     if (stat_i.div_done) state_d = ST_MUL;
      ST_MUL:     state_d = ST_RELOAD;
      ST_RELOAD:  if (stat_i.div_done) state_d = ST_PH_GO;
      ST_PH_GO:   state_d = ST_PH;
      ST_PH:      if (stat_i.div_done) state_d = ST_FRAC_GO;
      ST_FRAC_GO: state_d = ST_FRAC;
      ST_FRAC:    if (stat_i.div_done) state_d = ST_DONE;
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_COUNT;
    case (state_q)
      ST_IDLE: cmd_o.load_in = in_valid_i;
      ST_APPLY: begin
        cmd_o.apply     = 1'b1;
        // Remainder against the old period feeds the reload product.
        cmd_o.div_start = stat_i.reload_needed;
        cmd_o.div_sel   = DIV_COUNT;
      end
      ST_REM:   cmd_o.mul_load = stat_i.div_done;
      ST_MUL: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_PRODUCT;
      end
      ST_RELOAD: cmd_o.commit_reload = stat_i.div_done;
      ST_PH_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_COUNT;
      end
      ST_PH:    cmd_o.ph_load = stat_i.div_done;
      ST_FRAC_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_FRACTION;
      end
      ST_FRAC:  cmd_o.turns_load = stat_i.div_done;
      ST_DONE:  cmd_o.out_load = out_free;
      default:  ;
    endcase
  end

  // Hold the beat until the receiver takes it.
  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/phase_generator_period_retime.sv
// Top level of the phase generator with phase-keeping period change.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one command beat:
// tick, set period, start or stop. Output channel (out_valid_o / out_stall_i /
// out_data_o) returns exactly one result beat per command: tick count, phase
// tick, phase as a 16-bit fraction of a turn, period in effect, run flag.
// One item is worked at a time. Modulo and fraction come from a shared
// restoring divider that retires one quotient bit per cycle over DW bits,
// DW = max(TICK_BITS, 32). A tick, start, stop or unchanged set period
// runs two divisions; a set period that changes the period runs two more.
// The result sits in an output register, so the next command is accepted
// while the receiver stalls; a finished item waits only when the previous
// result has not been taken yet.
// Reset clears the counter, stops counting and sets the period to MAX_PERIOD;
// no clearing pass is needed.
module phase_generator_period_retime
  import pgpr_pkg::*;
#(
  parameter int unsigned MIN_PERIOD = 2,
  parameter int unsigned MAX_PERIOD = 65535,
  parameter int unsigned TICK_BITS  = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  pgpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  pgpr_dpath #(
    .MIN_PERIOD (MIN_PERIOD),
    .MAX_PERIOD (MAX_PERIOD),
    .TICK_BITS  (TICK_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_data_o (out_data_o)
  );

endmodule
